// ===== rtl/core/integer_to_ascii_formatter_assert.svh =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter assertion macros
// implication checks on the rising clock edge, disabled during reset
// ----------------------------------------------------------------------------
`ifndef INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH
`define INTEGER_TO_ASCII_FORMATTER_ASSERT_SVH

// same-cycle implication
`define I2A_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define I2A_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/core/i2a_pkg.sv =====
// ----------------------------------------------------------------------------
// i2a_pkg
// types, widths, microcode table and character helpers of the formatter
// ----------------------------------------------------------------------------
package i2a_pkg;

  localparam int INT_BITS  = 32;
  localparam int LONG_BITS = 32;

  // argument widths, clamped to 1..64
  localparam int INT_W  = (INT_BITS > 64) ? 64 : ((INT_BITS < 1) ? 1 : INT_BITS);
  localparam int LONG_W = (LONG_BITS > 64) ? 64 : ((LONG_BITS < 1) ? 1 : LONG_BITS);

  localparam int VAL_W      = 64;
  localparam int CNT_W      = 7;
  localparam int BCD_DIGITS = 20;
  localparam int BCD_W      = BCD_DIGITS * 4;
  localparam int STEP_W     = 4;

  localparam logic [VAL_W-1:0] INT_MASK  =
    (INT_W >= 64) ? {VAL_W{1'b1}} : ((64'd1 << INT_W) - 64'd1);
  localparam logic [VAL_W-1:0] LONG_MASK =
    (LONG_W >= 64) ? {VAL_W{1'b1}} : ((64'd1 << LONG_W) - 64'd1);

  // alignment shifts that put the top digit at the msb end
  localparam int INT_DSH   = VAL_W - INT_W;
  localparam int LONG_DSH  = VAL_W - LONG_W;
  localparam int INT_HDIG  = (INT_W + 3) / 4;
  localparam int LONG_HDIG = (LONG_W + 3) / 4;
  localparam int INT_HSH   = VAL_W - 4 * INT_HDIG;
  localparam int LONG_HSH  = VAL_W - 4 * LONG_HDIG;

  localparam logic [1:0] CMD_UDEC = 2'd0;
  localparam logic [1:0] CMD_SDEC = 2'd1;
  localparam logic [1:0] CMD_HEX  = 2'd2;
  localparam logic [1:0] CMD_PTR  = 2'd3;

  // jump conditions
  localparam logic [2:0] COND_NEVER  = 3'd0;
  localparam logic [2:0] COND_ALWAYS = 3'd1;
  localparam logic [2:0] COND_NSTART = 3'd2;
  localparam logic [2:0] COND_HEX    = 3'd3;
  localparam logic [2:0] COND_NOTNEG = 3'd4;
  localparam logic [2:0] COND_NOTPTR = 3'd5;
  localparam logic [2:0] COND_MORE   = 3'd6;
  localparam logic [2:0] COND_NZ     = 3'd7;

  // datapath operations
  localparam logic [3:0] OP_NOP      = 4'd0;
  localparam logic [3:0] OP_LOAD     = 4'd1;
  localparam logic [3:0] OP_NEG      = 4'd2;
  localparam logic [3:0] OP_DALIGN   = 4'd3;
  localparam logic [3:0] OP_DABBLE   = 4'd4;
  localparam logic [3:0] OP_SCANINIT = 4'd5;
  localparam logic [3:0] OP_SCAN     = 4'd6;
  localparam logic [3:0] OP_HALIGN   = 4'd7;
  localparam logic [3:0] OP_HSHIFT   = 4'd8;

  // character sources
  localparam logic [2:0] EM_NONE  = 3'd0;
  localparam logic [2:0] EM_MINUS = 3'd1;
  localparam logic [2:0] EM_ZERO  = 3'd2;
  localparam logic [2:0] EM_X     = 3'd3;
  localparam logic [2:0] EM_NIB   = 3'd4;
  localparam logic [2:0] EM_DIGIT = 3'd5;

  // program addresses
  localparam logic [STEP_W-1:0] PC_IDLE   = 4'd0;
  localparam logic [STEP_W-1:0] PC_NEG    = 4'd3;
  localparam logic [STEP_W-1:0] PC_DALIGN = 4'd4;
  localparam logic [STEP_W-1:0] PC_DABBLE = 4'd5;
  localparam logic [STEP_W-1:0] PC_SCAN   = 4'd7;
  localparam logic [STEP_W-1:0] PC_HEX    = 4'd9;
  localparam logic [STEP_W-1:0] PC_HALIGN = 4'd12;
  localparam logic [STEP_W-1:0] PC_HOUT   = 4'd13;

  typedef struct packed {
    logic [1:0]       cmd;
    logic             long_arg;
    logic [VAL_W-1:0] number;
  } req_t;

  typedef struct packed {
    logic [7:0] ch;
    logic       last;
  } res_t;

  typedef struct packed {
    logic [2:0]        cond;
    logic [STEP_W-1:0] target;
    logic [3:0]        op;
    logic [2:0]        emit;
  } ctrl_t;

  typedef struct packed {
    logic hex_mode;
    logic not_neg;
    logic not_ptr;
    logic more;
    logic nz;
  } flags_t;

  function automatic ctrl_t ucode(input logic [STEP_W-1:0] pc);
    ctrl_t w;
    case (pc)
      4'd0:    w = '{COND_NSTART, PC_IDLE,   OP_LOAD,     EM_NONE};
      4'd1:    w = '{COND_HEX,    PC_HEX,    OP_NOP,      EM_NONE};
      4'd2:    w = '{COND_NOTNEG, PC_DALIGN, OP_NOP,      EM_NONE};
      4'd3:    w = '{COND_NEVER,  PC_IDLE,   OP_NEG,      EM_MINUS};
      4'd4:    w = '{COND_NEVER,  PC_IDLE,   OP_DALIGN,   EM_NONE};
      4'd5:    w = '{COND_MORE,   PC_DABBLE, OP_DABBLE,   EM_NONE};
      4'd6:    w = '{COND_NEVER,  PC_IDLE,   OP_SCANINIT, EM_NONE};
      4'd7:    w = '{COND_NZ,     PC_SCAN,   OP_SCAN,     EM_DIGIT};
      4'd8:    w = '{COND_ALWAYS, PC_IDLE,   OP_NOP,      EM_NONE};
      4'd9:    w = '{COND_NOTPTR, PC_HALIGN, OP_NOP,      EM_NONE};
      4'd10:   w = '{COND_NEVER,  PC_IDLE,   OP_NOP,      EM_ZERO};
      4'd11:   w = '{COND_NEVER,  PC_IDLE,   OP_NOP,      EM_X};
      4'd12:   w = '{COND_NEVER,  PC_IDLE,   OP_HALIGN,   EM_NONE};
      4'd13:   w = '{COND_MORE,   PC_HOUT,   OP_HSHIFT,   EM_NIB};
      4'd14:   w = '{COND_ALWAYS, PC_IDLE,   OP_NOP,      EM_NONE};
      default: w = '{COND_ALWAYS, PC_IDLE,   OP_NOP,      EM_NONE};
    endcase
    return w;
  endfunction

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    logic [7:0] c;
    if (nib < 4'd10) begin
      c = 8'h30 + {4'd0, nib};
    end else begin
      c = 8'h57 + {4'd0, nib};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/i2a_useq.sv =====
// ----------------------------------------------------------------------------
// i2a_useq
// step counter and microcode table lookup with conditional jumps
// ----------------------------------------------------------------------------
module i2a_useq (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  i2a_pkg::flags_t flags,
  output i2a_pkg::ctrl_t ctrl,
  output logic           busy
);

  logic [i2a_pkg::STEP_W-1:0] step;
  logic [i2a_pkg::STEP_W-1:0] step_next;
  logic                       take;

  assign ctrl = i2a_pkg::ucode(step);
  assign busy = (step != i2a_pkg::PC_IDLE);

  always_comb begin
    case (ctrl.cond)
      i2a_pkg::COND_NEVER:  take = 1'b0;
      i2a_pkg::COND_ALWAYS: take = 1'b1;
      i2a_pkg::COND_NSTART: take = !start;
      i2a_pkg::COND_HEX:    take = flags.hex_mode;
      i2a_pkg::COND_NOTNEG: take = flags.not_neg;
      i2a_pkg::COND_NOTPTR: take = flags.not_ptr;
      i2a_pkg::COND_MORE:   take = flags.more;
      i2a_pkg::COND_NZ:     take = flags.nz;
      default:              take = 1'b1;
    endcase
    step_next = take ? ctrl.target : step + 4'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step <= i2a_pkg::PC_IDLE;
    end else begin
      step <= step_next;
    end
  end

endmodule

// ===== rtl/core/i2a_dpath.sv =====
// ----------------------------------------------------------------------------
// i2a_dpath
// value shifter, bcd double-dabble register, counter and character output
// ----------------------------------------------------------------------------
module i2a_dpath (
  input  logic            clk,
  input  logic            rst,
  input  logic            start,
  input  i2a_pkg::req_t   req,
  input  i2a_pkg::ctrl_t  ctrl,
  output i2a_pkg::flags_t flags,
  output i2a_pkg::res_t   res,
  output logic            strobe
);

  logic [i2a_pkg::VAL_W-1:0] val;
  logic [i2a_pkg::BCD_W-1:0] bcd;
  logic [i2a_pkg::BCD_W-1:0] bcd_adj;
  logic [i2a_pkg::CNT_W-1:0] cnt;
  logic [1:0]                cmd;
  logic                      wide;
  logic                      started;
  logic [i2a_pkg::VAL_W-1:0] mask;
  logic                      sign;
  logic [3:0]                digit;
  logic                      go;
  logic [7:0]                ch_next;
  logic                      last_next;
  logic                      req_wide;

  assign req_wide = req.long_arg || (req.cmd == i2a_pkg::CMD_PTR);
  assign mask     = wide ? i2a_pkg::LONG_MASK : i2a_pkg::INT_MASK;
  assign sign     = wide ? val[i2a_pkg::LONG_W-1] : val[i2a_pkg::INT_W-1];
  assign digit    = bcd[7'(cnt[4:0]) * 7'd4 +: 4];

  assign flags.hex_mode = cmd[1];
  assign flags.not_neg  = !((cmd == i2a_pkg::CMD_SDEC) && sign);
  assign flags.not_ptr  = (cmd != i2a_pkg::CMD_PTR);
  assign flags.more     = (cnt != 7'd1);
  assign flags.nz       = (cnt != 7'd0);

  // add-3 correction on every bcd digit
  always_comb begin
    for (int i = 0; i < i2a_pkg::BCD_DIGITS; i++) begin
      if (bcd[i*4 +: 4] >= 4'd5) begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4] + 4'd3;
      end else begin
        bcd_adj[i*4 +: 4] = bcd[i*4 +: 4];
      end
    end
  end

  always_comb begin
    go        = 1'b1;
    last_next = 1'b0;
    case (ctrl.emit)
      i2a_pkg::EM_NONE: begin
        go      = 1'b0;
        ch_next = 8'h00;
      end
      i2a_pkg::EM_MINUS: ch_next = 8'h2d;
      i2a_pkg::EM_ZERO:  ch_next = 8'h30;
      i2a_pkg::EM_X:     ch_next = 8'h78;
      i2a_pkg::EM_NIB: begin
        ch_next   = i2a_pkg::hex_char(val[i2a_pkg::VAL_W-1 -: 4]);
        last_next = (cnt == 7'd1);
      end
      i2a_pkg::EM_DIGIT: begin
        ch_next   = i2a_pkg::hex_char(digit);
        last_next = (cnt == 7'd0);
        go        = (digit != 4'd0) || started || (cnt == 7'd0);
      end
      default: begin
        go      = 1'b0;
        ch_next = 8'h00;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      i2a_pkg::OP_LOAD: begin
        if (start) begin
          cmd  <= req.cmd;
          wide <= req_wide;
          val  <= req.number &
                  (req_wide ? i2a_pkg::LONG_MASK : i2a_pkg::INT_MASK);
        end
      end
      i2a_pkg::OP_NEG: val <= (~val + 64'd1) & mask;
      i2a_pkg::OP_DALIGN: begin
        val <= wide ? (val << i2a_pkg::LONG_DSH) : (val << i2a_pkg::INT_DSH);
        bcd <= '0;
        cnt <= wide ? 7'(i2a_pkg::LONG_W) : 7'(i2a_pkg::INT_W);
      end
      i2a_pkg::OP_DABBLE: begin
        bcd <= {bcd_adj[i2a_pkg::BCD_W-2:0], val[i2a_pkg::VAL_W-1]};
        val <= val << 1;
        cnt <= cnt - 7'd1;
      end
      i2a_pkg::OP_SCANINIT: begin
        cnt     <= 7'(i2a_pkg::BCD_DIGITS - 1);
        started <= 1'b0;
      end
      i2a_pkg::OP_SCAN: begin
        cnt <= cnt - 7'd1;
        if (go) begin
          started <= 1'b1;
        end
      end
      i2a_pkg::OP_HALIGN: begin
        val <= wide ? (val << i2a_pkg::LONG_HSH) : (val << i2a_pkg::INT_HSH);
        cnt <= wide ? 7'(i2a_pkg::LONG_HDIG) : 7'(i2a_pkg::INT_HDIG);
      end
      i2a_pkg::OP_HSHIFT: begin
        val <= val << 4;
        cnt <= cnt - 7'd1;
      end
      default: begin
      end
    endcase
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      strobe <= 1'b0;
    end else begin
      strobe <= go;
    end
  end

  always_ff @(posedge clk) begin
    res.ch   <= ch_next;
    res.last <= last_next;
  end

endmodule

// ===== rtl/core/integer_to_ascii_formatter.sv =====
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// one number in, its ascii characters out one per strobe, last one marked
// ----------------------------------------------------------------------------
// order: the first character is the 0 of the 0x prefix for pointer, the top digit for hex,
//   the minus for negative decimal; other decimal runs the double-dabble loop first
// requests: one at a time; a new request is taken only while idle, and the run
//   length grows with the argument width W, set by the loop
// characters come at most one per cycle and cannot be stalled by the receiver
// reset: synchronous, clears the step counter and strobe; block is then idle
`include "integer_to_ascii_formatter_assert.svh"

module integer_to_ascii_formatter (
  input  logic          clk,
  input  logic          rst,
  input  logic          start,
  input  i2a_pkg::req_t req,
  output logic          busy,
  output i2a_pkg::res_t res,
  output logic          strobe
);

  i2a_pkg::ctrl_t  ctrl;
  i2a_pkg::flags_t flags;

  i2a_useq u_useq (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .flags (flags),
    .ctrl  (ctrl),
    .busy  (busy)
  );

  i2a_dpath u_dpath (
    .clk    (clk),
    .rst    (rst),
    .start  (start),
    .req    (req),
    .ctrl   (ctrl),
    .flags  (flags),
    .res    (res),
    .strobe (strobe)
  );

  `I2A_ASSERT_NXT(a_accept_busy, clk, rst, start && !busy, busy, "request not taken")
  `I2A_ASSERT_IMP(a_strobe_in_run, clk, rst, strobe, $past(busy), "strobe while idle")
  `I2A_ASSERT_NXT(a_last_gap, clk, rst, strobe && res.last, !strobe, "char after last")
  `I2A_ASSERT_NXT(a_more_chars, clk, rst, strobe && !res.last, busy, "run ended early")

endmodule
